// ----- rtl/ncdc_pkg.sv -----
// shared types, widths and codes for the nearest-centroid data cost block
`timescale 1ns / 1ps
`default_nettype none

package ncdc_pkg;

  localparam int CH_W    = 12;            // centroid channel, unsigned 8.4
  localparam int PIX_W   = 8;             // pixel and markup byte
  localparam int SLOT_W  = 6;             // slot field of a load item
  localparam int SQ_W    = 26;            // sum of three 12-bit squares
  localparam int RAD_W   = SQ_W + 16;     // squared distance scaled to Q.12 after root
  localparam int ROOT_W  = RAD_W / 2;     // truncated distance
  localparam int DEN_W   = ROOT_W + 1;    // sum of two distances
  localparam int COST_W  = 23;            // cost output width

  localparam logic [6:0] SEED_COST = 7'd100;

  localparam logic CMD_LOAD     = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  localparam logic SET_BACKGROUND = 1'b0;
  localparam logic SET_FOREGROUND = 1'b1;

  localparam logic [PIX_W-1:0] MARK_LO = 8'd0;
  localparam logic [PIX_W-1:0] MARK_HI = 8'd255;

  typedef enum logic [1:0] {
    CLASS_UNCERTAIN = 2'd0,
    CLASS_FG_SEED   = 2'd1,
    CLASS_BG_SEED   = 2'd2
  } pix_class_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_ROOT,
    ST_DIVIDE
  } state_t;

  typedef struct packed {
    logic [CH_W-1:0] c2;
    logic [CH_W-1:0] c1;
    logic [CH_W-1:0] c0;
  } cent_t;

  typedef struct packed {
    logic [PIX_W-1:0] c2;
    logic [PIX_W-1:0] c1;
    logic [PIX_W-1:0] c0;
  } pix_t;

  // centroid table write
  typedef struct packed {
    logic              en;
    logic              set;
    logic [SLOT_W-1:0] slot;
    cent_t             cent;
  } wr_t;

  function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ncdc_search.sv -----
// centroid memories and the sweep that finds the minimum squared distance per table
`timescale 1ns / 1ps
`default_nettype none

module ncdc_search #(
  parameter int NUM_CENTROIDS = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire ncdc_pkg::wr_t             wr,
  input  wire logic                      start,
  input  wire ncdc_pkg::pix_t            pix,
  output logic                           done,
  output logic [ncdc_pkg::SQ_W-1:0]      min_fg,
  output logic [ncdc_pkg::SQ_W-1:0]      min_bg
);

  localparam int AW = (NUM_CENTROIDS > 1) ? $clog2(NUM_CENTROIDS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_CENTROIDS - 1);
  localparam int SQR_W = 2 * ncdc_pkg::CH_W;

  ncdc_pkg::cent_t fg_mem [NUM_CENTROIDS];
  ncdc_pkg::cent_t bg_mem [NUM_CENTROIDS];

  logic                 run_r;
  logic [AW-1:0]        rd_addr_r;
  logic                 d_vld_r, d_last_r;
  logic                 sq_vld_r, sq_last_r;
  logic                 done_r;
  ncdc_pkg::cent_t      rd_fg_r, rd_bg_r;
  logic [ncdc_pkg::CH_W-1:0] px0_r, px1_r, px2_r;
  logic [SQR_W-1:0]     sqf0_r, sqf1_r, sqf2_r;
  logic [SQR_W-1:0]     sqb0_r, sqb1_r, sqb2_r;
  logic [ncdc_pkg::SQ_W-1:0] min_fg_r, min_bg_r;
  logic [ncdc_pkg::SQ_W-1:0] sum_fg, sum_bg;
  logic [ncdc_pkg::CH_W-1:0] df0, df1, df2, db0, db1, db2;

  // table write and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (wr.set == ncdc_pkg::SET_FOREGROUND) begin
        fg_mem[AW'(wr.slot)] <= wr.cent;
      end else begin
        bg_mem[AW'(wr.slot)] <= wr.cent;
      end
    end
    rd_fg_r <= fg_mem[rd_addr_r];
    rd_bg_r <= bg_mem[rd_addr_r];
  end

  // address sweep and valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r     <= 1'b0;
      rd_addr_r <= '0;
      d_vld_r   <= 1'b0;
      d_last_r  <= 1'b0;
      sq_vld_r  <= 1'b0;
      sq_last_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      if (start) begin
        run_r     <= 1'b1;
        rd_addr_r <= '0;
      end else if (run_r) begin
        rd_addr_r <= rd_addr_r + AW'(1);
        if (rd_addr_r == LAST_ADDR) begin
          run_r <= 1'b0;
        end
      end
      d_vld_r   <= run_r;
      d_last_r  <= run_r && (rd_addr_r == LAST_ADDR);
      sq_vld_r  <= d_vld_r;
      sq_last_r <= d_last_r;
      done_r    <= sq_vld_r && sq_last_r;
    end
  end

  always_comb begin
    df0 = ncdc_pkg::abs_diff(rd_fg_r.c0, px0_r);
    df1 = ncdc_pkg::abs_diff(rd_fg_r.c1, px1_r);
    df2 = ncdc_pkg::abs_diff(rd_fg_r.c2, px2_r);
    db0 = ncdc_pkg::abs_diff(rd_bg_r.c0, px0_r);
    db1 = ncdc_pkg::abs_diff(rd_bg_r.c1, px1_r);
    db2 = ncdc_pkg::abs_diff(rd_bg_r.c2, px2_r);
    sum_fg = ncdc_pkg::SQ_W'(sqf0_r) + ncdc_pkg::SQ_W'(sqf1_r) + ncdc_pkg::SQ_W'(sqf2_r);
    sum_bg = ncdc_pkg::SQ_W'(sqb0_r) + ncdc_pkg::SQ_W'(sqb1_r) + ncdc_pkg::SQ_W'(sqb2_r);
  end

  // squares, then sum and running minimum
  always_ff @(posedge clk) begin
    if (start) begin
      px0_r    <= {pix.c0, 4'b0000};
      px1_r    <= {pix.c1, 4'b0000};
      px2_r    <= {pix.c2, 4'b0000};
      min_fg_r <= '1;
      min_bg_r <= '1;
    end else if (sq_vld_r) begin
      if (sum_fg < min_fg_r) begin
        min_fg_r <= sum_fg;
      end
      if (sum_bg < min_bg_r) begin
        min_bg_r <= sum_bg;
      end
    end
    sqf0_r <= df0 * df0;
    sqf1_r <= df1 * df1;
    sqf2_r <= df2 * df2;
    sqb0_r <= db0 * db0;
    sqb1_r <= db1 * db1;
    sqb2_r <= db2 * db2;
  end

  assign done   = done_r;
  assign min_fg = min_fg_r;
  assign min_bg = min_bg_r;

endmodule

`default_nettype wire

// ----- rtl/ncdc_sqrt.sv -----
// bit-serial integer square root of a scaled squared distance
`timescale 1ns / 1ps
`default_nettype none

module ncdc_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [ncdc_pkg::SQ_W-1:0]   sq,
  output logic                             done,
  output logic [ncdc_pkg::ROOT_W-1:0]      root
);

  localparam int RW = ncdc_pkg::RAD_W;

  logic          busy_r, done_r;
  logic [RW-1:0] v_r, res_r, bit_r;
  logic [RW-1:0] v_nxt, res_nxt, trial;

  always_comb begin
    trial   = res_r + bit_r;
    v_nxt   = v_r;
    res_nxt = res_r >> 1;
    if (v_r >= trial) begin
      v_nxt   = v_r - trial;
      res_nxt = (res_r >> 1) + bit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= {sq, 16'h0000};
      res_r <= '0;
      bit_r <= RW'(1) << (RW - 2);
    end else if (busy_r) begin
      v_r   <= v_nxt;
      res_r <= res_nxt;
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[ncdc_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/ncdc_div.sv -----
// restoring divider for one fractional cost, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module ncdc_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [ncdc_pkg::ROOT_W-1:0] num,
  input  wire logic [ncdc_pkg::DEN_W-1:0]  den,
  output logic                             done,
  output logic [FRAC_BITS:0]               quot
);

  localparam int DW    = ncdc_pkg::DEN_W;
  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0]    rem_r, den_r;
  logic [FRAC_BITS:0] q_r;
  logic [DW-1:0]    num_ext;
  logic             q_top;
  logic [DW:0]      rem2;
  logic             ge;
  logic [DW-1:0]    rem_nxt;

  always_comb begin
    num_ext = DW'(num);
    q_top   = (num_ext >= den);
    rem2    = {rem_r, 1'b0};
    ge      = (rem2 >= {1'b0, den_r});
    rem_nxt = ge ? DW'(rem2 - {1'b0, den_r}) : DW'(rem2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(FRAC_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // integer quotient bit first, then one fraction bit per step
  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= q_top ? (num_ext - den) : num_ext;
      q_r   <= {{FRAC_BITS{1'b0}}, q_top};
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[FRAC_BITS-1:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire

// ----- rtl/nearest_centroid_data_cost.sv -----
// top level of the nearest-centroid data cost block
`timescale 1ns / 1ps
`default_nettype none

// usage
// - one command channel: an item is taken at a rising edge with start high and
//   busy low; in_command selects a centroid load or a pixel classify
// - a load writes one foreground or background centroid in the accept cycle and
//   gives no result; a slot at or beyond NUM_CENTROIDS is dropped
// - a classify item gives one result, shown for one cycle with out_valid high;
//   the receiver has no way to hold it off, so it must take it in that cycle
// - seed markups (pure blue foreground, pure red background) give their fixed
//   costs in the cycle after accept, with busy staying low
// - any other markup sweeps both centroid memories together, one entry per
//   cycle, then takes two square roots (one bit per cycle) and two divisions
//   (one quotient bit per cycle); when both distances are zero no division
//   is needed and the result follows straight after the roots
// - busy is high through that work, so the rate is set by the memory sweep,
//   the 21-step root and the divider; a new item may be taken in the cycle the
//   result is shown
// - reset clears control only; centroid memories hold garbage until loaded

module nearest_centroid_data_cost #(
  parameter int NUM_CENTROIDS  = 64,
  parameter int COST_FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_command,
  input  wire logic                          in_centroid_set,
  input  wire logic [ncdc_pkg::SLOT_W-1:0]   in_centroid_slot,
  input  wire logic [ncdc_pkg::CH_W-1:0]     in_cent_c0,
  input  wire logic [ncdc_pkg::CH_W-1:0]     in_cent_c1,
  input  wire logic [ncdc_pkg::CH_W-1:0]     in_cent_c2,
  input  wire logic [ncdc_pkg::PIX_W-1:0]    in_pix_c0,
  input  wire logic [ncdc_pkg::PIX_W-1:0]    in_pix_c1,
  input  wire logic [ncdc_pkg::PIX_W-1:0]    in_pix_c2,
  input  wire logic [ncdc_pkg::PIX_W-1:0]    in_mark_c0,
  input  wire logic [ncdc_pkg::PIX_W-1:0]    in_mark_c1,
  input  wire logic [ncdc_pkg::PIX_W-1:0]    in_mark_c2,
  output logic                               out_valid,
  output logic [ncdc_pkg::COST_W-1:0]        out_cost_label_zero,
  output logic [ncdc_pkg::COST_W-1:0]        out_cost_label_one,
  output logic [1:0]                         out_pixel_class
);

  // wide enough for the seed cost before it is cut to the port width
  localparam int WIDE_W = (COST_FRAC_BITS + 7 > ncdc_pkg::COST_W) ?
                          COST_FRAC_BITS + 7 : ncdc_pkg::COST_W;
  localparam logic [8:0] NUM_C9 = 9'(NUM_CENTROIDS);

  ncdc_pkg::state_t state_r, state_nxt;

  logic accept, classify, fg_seed, bg_seed, seed, slot_ok;
  ncdc_pkg::wr_t  wr;
  ncdc_pkg::pix_t pix;

  // unit handshakes
  logic srch_start, srch_done;
  logic root_start, root_done_f, root_done_b;
  logic div_start, div_done_0, div_done_1;
  logic out_load;

  logic [ncdc_pkg::SQ_W-1:0]   min_fg, min_bg;
  logic [ncdc_pkg::ROOT_W-1:0] root_f, root_b;
  logic [ncdc_pkg::DEN_W-1:0]  den;
  logic                        den_zero;
  logic [COST_FRAC_BITS:0]     quot_0, quot_1;
  logic [WIDE_W-1:0]           seed_wide;

  logic                          out_valid_r;
  logic [ncdc_pkg::COST_W-1:0]   cost0_r, cost1_r, cost0_nxt, cost1_nxt;
  ncdc_pkg::pix_class_t          class_r, class_nxt;

  // item decode
  always_comb begin
    accept   = start && !busy;
    classify = accept && (in_command == ncdc_pkg::CMD_CLASSIFY);
    fg_seed  = (in_mark_c0 == ncdc_pkg::MARK_LO) && (in_mark_c1 == ncdc_pkg::MARK_LO) &&
               (in_mark_c2 == ncdc_pkg::MARK_HI);
    bg_seed  = (in_mark_c0 == ncdc_pkg::MARK_HI) && (in_mark_c1 == ncdc_pkg::MARK_LO) &&
               (in_mark_c2 == ncdc_pkg::MARK_LO);
    seed     = fg_seed || bg_seed;
    slot_ok  = ({3'b000, in_centroid_slot} < NUM_C9);

    wr.en      = accept && (in_command == ncdc_pkg::CMD_LOAD) && slot_ok;
    wr.set     = in_centroid_set;
    wr.slot    = in_centroid_slot;
    wr.cent.c0 = in_cent_c0;
    wr.cent.c1 = in_cent_c1;
    wr.cent.c2 = in_cent_c2;

    pix.c0 = in_pix_c0;
    pix.c1 = in_pix_c1;
    pix.c2 = in_pix_c2;

    den      = {1'b0, root_f} + {1'b0, root_b};
    den_zero = (den == '0);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ncdc_pkg::ST_IDLE: begin
        if (classify && !seed) begin
          state_nxt = ncdc_pkg::ST_SEARCH;
        end
      end
      ncdc_pkg::ST_SEARCH: begin
        if (srch_done) begin
          state_nxt = ncdc_pkg::ST_ROOT;
        end
      end
      ncdc_pkg::ST_ROOT: begin
        if (root_done_f) begin
          state_nxt = den_zero ? ncdc_pkg::ST_IDLE : ncdc_pkg::ST_DIVIDE;
        end
      end
      ncdc_pkg::ST_DIVIDE: begin
        if (div_done_1) begin
          state_nxt = ncdc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ncdc_pkg::ST_IDLE;
    endcase
  end

  // control outputs and result selection
  always_comb begin
    busy       = (state_r != ncdc_pkg::ST_IDLE);
    srch_start = 1'b0;
    root_start = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    seed_wide  = WIDE_W'(ncdc_pkg::SEED_COST) << COST_FRAC_BITS;
    cost0_nxt  = '0;
    cost1_nxt  = '0;
    class_nxt  = ncdc_pkg::CLASS_UNCERTAIN;
    unique case (state_r)
      ncdc_pkg::ST_IDLE: begin
        srch_start = classify && !seed;
        out_load   = classify && seed;
        if (fg_seed) begin
          cost0_nxt = ncdc_pkg::COST_W'(seed_wide);
          class_nxt = ncdc_pkg::CLASS_FG_SEED;
        end else begin
          cost1_nxt = ncdc_pkg::COST_W'(seed_wide);
          class_nxt = ncdc_pkg::CLASS_BG_SEED;
        end
      end
      ncdc_pkg::ST_SEARCH: begin
        root_start = srch_done;
      end
      ncdc_pkg::ST_ROOT: begin
        // both distances zero: both costs stay zero
        div_start = root_done_f && !den_zero;
        out_load  = root_done_f && den_zero;
      end
      ncdc_pkg::ST_DIVIDE: begin
        out_load  = div_done_1;
        cost0_nxt = ncdc_pkg::COST_W'(WIDE_W'(quot_0));
        cost1_nxt = ncdc_pkg::COST_W'(WIDE_W'(quot_1));
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ncdc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_load;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (out_load) begin
      cost0_r <= cost0_nxt;
      cost1_r <= cost1_nxt;
      class_r <= class_nxt;
    end
  end

  ncdc_search #(
    .NUM_CENTROIDS(NUM_CENTROIDS)
  ) u_search (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr),
    .start  (srch_start),
    .pix    (pix),
    .done   (srch_done),
    .min_fg (min_fg),
    .min_bg (min_bg)
  );

  ncdc_sqrt u_sqrt_fg (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .sq    (min_fg),
    .done  (root_done_f),
    .root  (root_f)
  );

  ncdc_sqrt u_sqrt_bg (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .sq    (min_bg),
    .done  (root_done_b),
    .root  (root_b)
  );

  // label 0 cost follows the background distance
  ncdc_div #(
    .FRAC_BITS(COST_FRAC_BITS)
  ) u_div_zero (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (root_b),
    .den   (den),
    .done  (div_done_0),
    .quot  (quot_0)
  );

  // label 1 cost follows the foreground distance
  ncdc_div #(
    .FRAC_BITS(COST_FRAC_BITS)
  ) u_div_one (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (root_f),
    .den   (den),
    .done  (div_done_1),
    .quot  (quot_1)
  );

  assign out_valid           = out_valid_r;
  assign out_cost_label_zero = cost0_r;
  assign out_cost_label_one  = cost1_r;
  assign out_pixel_class     = class_r;

`ifndef ASSERT_OFF
  // the two root units run in lock step
  a_root_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    root_done_f == root_done_b)
    else $error("square root units out of step");

  // the two dividers run in lock step
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    div_done_0 == div_done_1)
    else $error("dividers out of step");

  // the sweep only finishes while the sequencer waits for it
  a_search_state: assert property (@(posedge clk) disable iff (!rst_n)
    srch_done |-> (state_r == ncdc_pkg::ST_SEARCH))
    else $error("search done outside search state");

  // a long classify always ends with its result
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");
`endif

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// self-checking testbench for the nearest-centroid data cost block
`timescale 1ns / 1ps

module tb_top;
  import ncdc_pkg::*;

  localparam int NUM_CENT     = 64;
  localparam int FRAC_BITS    = 16;
  // upper bound on the time from accept to strobe for a pixel that needs the full search
  localparam int SEARCH_LAT   = NUM_CENT + FRAC_BITS + 27;
  localparam int RANDOM_ITEMS = 300;
  // worst case is every item a full search plus the longest sender gap,
  // taken several times over
  localparam int LIMIT_CYCLES = 400000;

  // one command item as it appears on the input ports
  typedef struct packed {
    logic              command;
    logic              set;
    logic [SLOT_W-1:0] slot;
    cent_t             cent;
    pix_t              pix;
    pix_t              mark;
  } cmd_item_t;

  // one result item as it appears on the output ports
  typedef struct packed {
    logic [COST_W-1:0] cost_zero;
    logic [COST_W-1:0] cost_one;
    pix_class_t        cls;
  } cost_result_t;

  // mirror of both centroid tables plus the queue of costs still to come
  class cost_scoreboard;
    cent_t        fg_tab [NUM_CENT];
    cent_t        bg_tab [NUM_CENT];
    cost_result_t pending_costs [$];
    int           mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    function int pending_count();
      return pending_costs.size();
    endfunction

    // bitwise integer square root, truncating
    function longint unsigned int_root(longint unsigned v);
      longint unsigned rem;
      longint unsigned res;
      longint unsigned bitv;
      rem  = v;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (rem >= res + bitv) begin
          rem = rem - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // smallest squared distance from the scaled pixel to any table entry
    function longint unsigned nearest_sq(input bit use_fg, input pix_t p);
      longint unsigned best;
      longint unsigned s;
      longint unsigned d;
      logic [CH_W-1:0] pc [3];
      logic [CH_W-1:0] cc [3];
      cent_t           e;
      best  = 64'hFFFF_FFFF_FFFF_FFFF;
      pc[0] = {p.c0, 4'b0};
      pc[1] = {p.c1, 4'b0};
      pc[2] = {p.c2, 4'b0};
      for (int k = 0; k < NUM_CENT; k++) begin
        e     = use_fg ? fg_tab[k] : bg_tab[k];
        cc[0] = e.c0;
        cc[1] = e.c1;
        cc[2] = e.c2;
        s = 0;
        for (int c = 0; c < 3; c++) begin
          d = (cc[c] >= pc[c]) ? longint'(cc[c] - pc[c]) : longint'(pc[c] - cc[c]);
          s = s + d * d;
        end
        if (s < best) best = s;
      end
      return best;
    endfunction

    function cost_result_t predict_costs(input pix_t p, input pix_t m);
      cost_result_t    r;
      longint unsigned rf;
      longint unsigned rb;
      longint unsigned den;
      longint unsigned q;
      r.cost_zero = '0;
      r.cost_one  = '0;
      r.cls       = CLASS_UNCERTAIN;
      if (m.c0 == MARK_LO && m.c1 == MARK_LO && m.c2 == MARK_HI) begin
        r.cost_zero = COST_W'(SEED_COST) << FRAC_BITS;
        r.cls       = CLASS_FG_SEED;
      end else if (m.c0 == MARK_HI && m.c1 == MARK_LO && m.c2 == MARK_LO) begin
        r.cost_one  = COST_W'(SEED_COST) << FRAC_BITS;
        r.cls       = CLASS_BG_SEED;
      end else begin
        rf  = int_root(nearest_sq(1'b1, p) << 16);
        rb  = int_root(nearest_sq(1'b0, p) << 16);
        den = rf + rb;
        if (den != 0) begin
          q           = (rf << FRAC_BITS) / den;
          r.cost_one  = q[COST_W-1:0];
          q           = (rb << FRAC_BITS) / den;
          r.cost_zero = q[COST_W-1:0];
        end
      end
      return r;
    endfunction

    // called for every accepted item
    function void note_item(input cmd_item_t it);
      if (it.command == CMD_LOAD) begin
        if (it.slot < NUM_CENT) begin
          if (it.set == SET_FOREGROUND) fg_tab[it.slot] = it.cent;
          else bg_tab[it.slot] = it.cent;
        end
      end else begin
        pending_costs.push_back(predict_costs(it.pix, it.mark));
      end
    endfunction

    // called for every strobed result
    function void check_result(input cost_result_t got);
      cost_result_t exp_r;
      if (pending_costs.size() == 0) begin
        $display("%0t: unexpected result cost0=%0d cost1=%0d class=%0d",
                 $time, got.cost_zero, got.cost_one, got.cls);
        mismatch_count++;
        return;
      end
      exp_r = pending_costs.pop_front();
      if (got.cost_zero !== exp_r.cost_zero) begin
        $display("%0t: cost_label_zero expected %0d actual %0d",
                 $time, exp_r.cost_zero, got.cost_zero);
        mismatch_count++;
      end
      if (got.cost_one !== exp_r.cost_one) begin
        $display("%0t: cost_label_one expected %0d actual %0d",
                 $time, exp_r.cost_one, got.cost_one);
        mismatch_count++;
      end
      if (got.cls !== exp_r.cls) begin
        $display("%0t: pixel_class expected %0d actual %0d",
                 $time, exp_r.cls, got.cls);
        mismatch_count++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_command;
  logic              in_centroid_set;
  logic [SLOT_W-1:0] in_centroid_slot;
  logic [CH_W-1:0]   in_cent_c0;
  logic [CH_W-1:0]   in_cent_c1;
  logic [CH_W-1:0]   in_cent_c2;
  logic [PIX_W-1:0]  in_pix_c0;
  logic [PIX_W-1:0]  in_pix_c1;
  logic [PIX_W-1:0]  in_pix_c2;
  logic [PIX_W-1:0]  in_mark_c0;
  logic [PIX_W-1:0]  in_mark_c1;
  logic [PIX_W-1:0]  in_mark_c2;
  logic              out_valid;
  logic [COST_W-1:0] out_cost_label_zero;
  logic [COST_W-1:0] out_cost_label_one;
  logic [1:0]        out_pixel_class;

  cost_scoreboard sb;
  int             cycle_count;
  pix_t           last_grid_pix;   // pixel that sits exactly on a recently loaded centroid

  nearest_centroid_data_cost #(
    .NUM_CENTROIDS  (NUM_CENT),
    .COST_FRAC_BITS (FRAC_BITS)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_command          (in_command),
    .in_centroid_set     (in_centroid_set),
    .in_centroid_slot    (in_centroid_slot),
    .in_cent_c0          (in_cent_c0),
    .in_cent_c1          (in_cent_c1),
    .in_cent_c2          (in_cent_c2),
    .in_pix_c0           (in_pix_c0),
    .in_pix_c1           (in_pix_c1),
    .in_pix_c2           (in_pix_c2),
    .in_mark_c0          (in_mark_c0),
    .in_mark_c1          (in_mark_c1),
    .in_mark_c2          (in_mark_c2),
    .out_valid           (out_valid),
    .out_cost_label_zero (out_cost_label_zero),
    .out_cost_label_one  (out_cost_label_one),
    .out_pixel_class     (out_pixel_class)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog: a hung block ends the run as a failure
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // port monitor: sampled at the rising edge, before the block updates
  always @(posedge clk) begin : port_monitor
    cmd_item_t    seen;
    cost_result_t got;
    if (rst_n && start && !busy) begin
      seen.command = in_command;
      seen.set     = in_centroid_set;
      seen.slot    = in_centroid_slot;
      seen.cent.c0 = in_cent_c0;
      seen.cent.c1 = in_cent_c1;
      seen.cent.c2 = in_cent_c2;
      seen.pix.c0  = in_pix_c0;
      seen.pix.c1  = in_pix_c1;
      seen.pix.c2  = in_pix_c2;
      seen.mark.c0 = in_mark_c0;
      seen.mark.c1 = in_mark_c1;
      seen.mark.c2 = in_mark_c2;
      sb.note_item(seen);
    end
    if (rst_n && out_valid) begin
      got.cost_zero = out_cost_label_zero;
      got.cost_one  = out_cost_label_one;
      got.cls       = pix_class_t'(out_pixel_class);
      sb.check_result(got);
    end
  end

  // every field random, so bits that the command ignores still toggle
  function automatic cmd_item_t noise_item();
    cmd_item_t it;
    it.command = 1'($urandom_range(0, 1));
    it.set     = 1'($urandom_range(0, 1));
    it.slot    = SLOT_W'($urandom_range(0, 63));
    it.cent.c0 = CH_W'($urandom_range(0, 4095));
    it.cent.c1 = CH_W'($urandom_range(0, 4095));
    it.cent.c2 = CH_W'($urandom_range(0, 4095));
    it.pix.c0  = PIX_W'($urandom_range(0, 255));
    it.pix.c1  = PIX_W'($urandom_range(0, 255));
    it.pix.c2  = PIX_W'($urandom_range(0, 255));
    it.mark.c0 = PIX_W'($urandom_range(0, 255));
    it.mark.c1 = PIX_W'($urandom_range(0, 255));
    it.mark.c2 = PIX_W'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic cmd_item_t load_item(input logic set, input int slot,
                                          input int c0, input int c1, input int c2);
    cmd_item_t it;
    it         = noise_item();
    it.command = CMD_LOAD;
    it.set     = set;
    it.slot    = SLOT_W'(slot);
    it.cent.c0 = CH_W'(c0);
    it.cent.c1 = CH_W'(c1);
    it.cent.c2 = CH_W'(c2);
    return it;
  endfunction

  function automatic cmd_item_t classify_item(input int p0, input int p1, input int p2,
                                              input int m0, input int m1, input int m2);
    cmd_item_t it;
    it         = noise_item();
    it.command = CMD_CLASSIFY;
    it.pix.c0  = PIX_W'(p0);
    it.pix.c1  = PIX_W'(p1);
    it.pix.c2  = PIX_W'(p2);
    it.mark.c0 = PIX_W'(m0);
    it.mark.c1 = PIX_W'(m1);
    it.mark.c2 = PIX_W'(m2);
    return it;
  endfunction

  // drive at the falling edge, hold until the block takes the item
  task automatic send_item(input cmd_item_t it);
    @(negedge clk);
    start            <= 1'b1;
    in_command       <= it.command;
    in_centroid_set  <= it.set;
    in_centroid_slot <= it.slot;
    in_cent_c0       <= it.cent.c0;
    in_cent_c1       <= it.cent.c1;
    in_cent_c2       <= it.cent.c2;
    in_pix_c0        <= it.pix.c0;
    in_pix_c1        <= it.pix.c1;
    in_pix_c2        <= it.pix.c2;
    in_mark_c0       <= it.mark.c0;
    in_mark_c1       <= it.mark.c1;
    in_mark_c2       <= it.mark.c2;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // sender holds off until every outstanding result has shown up
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_count() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    cmd_item_t it;
    int        kind;
    int        ch;
    sb = new();

    // every input known from time zero
    rst_n            = 1'b0;
    start            = 1'b0;
    in_command       = CMD_LOAD;
    in_centroid_set  = SET_BACKGROUND;
    in_centroid_slot = '0;
    in_cent_c0       = '0;
    in_cent_c1       = '0;
    in_cent_c2       = '0;
    in_pix_c0        = '0;
    in_pix_c1        = '0;
    in_pix_c2        = '0;
    in_mark_c0       = '0;
    in_mark_c1       = '0;
    in_mark_c2       = '0;
    last_grid_pix    = '0;

    repeat (13) @(negedge clk);
    rst_n <= 1'b1;

    // seeds never touch the tables, so they are safe before any load
    send_item(classify_item(255, 255, 255, 0, 0, 255));
    send_item(classify_item(0, 0, 0, 255, 0, 0));

    // fill every slot of both tables so no search reads an unwritten entry
    for (int s = 0; s < NUM_CENT; s++) begin
      send_item(load_item(SET_FOREGROUND, s, $urandom_range(0, 4095),
                          $urandom_range(0, 4095), $urandom_range(0, 4095)));
      send_item(load_item(SET_BACKGROUND, s, $urandom_range(0, 4095),
                          $urandom_range(0, 4095), $urandom_range(0, 4095)));
    end

    // directed: extremes of centroids and pixels
    send_item(load_item(SET_FOREGROUND, 0, 0, 0, 0));
    send_item(load_item(SET_BACKGROUND, 63, 4095, 4095, 4095));
    // pixel on a foreground centroid: label one costs nothing
    send_item(classify_item(0, 0, 0, 10, 20, 30));
    send_item(classify_item(255, 255, 255, 255, 255, 255));
    // pixel on a centroid in both tables: zero denominator, both costs zero
    send_item(load_item(SET_BACKGROUND, 5, 0, 0, 0));
    send_item(classify_item(0, 0, 0, 0, 0, 0));
    // markups one channel away from a seed fall through to the search
    send_item(classify_item(128, 64, 32, 0, 0, 254));
    send_item(classify_item(1, 2, 3, 0, 1, 255));
    send_item(classify_item(200, 100, 50, 128, 0, 255));
    send_item(classify_item(17, 250, 0, 255, 0, 1));
    send_item(classify_item(255, 0, 255, 255, 128, 0));
    send_item(classify_item(0, 255, 0, 254, 0, 0));
    // seeds back to back with extreme pixels
    send_item(classify_item(0, 0, 0, 0, 0, 255));
    send_item(classify_item(255, 255, 255, 255, 0, 0));
    send_item(classify_item(255, 255, 255, 0, 0, 255));
    // loads at both end slots and with extreme channel values
    send_item(load_item(SET_FOREGROUND, 63, 4095, 0, 4095));
    send_item(load_item(SET_BACKGROUND, 0, 0, 4095, 0));
    send_item(classify_item(255, 0, 255, 9, 9, 9));
    send_item(classify_item(0, 255, 0, 0, 255, 255));
    drain_results();

    // random part: mostly real loads and searches, some seeds and near-seeds
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = $urandom_range(0, 99);
      it   = noise_item();
      if (kind < 25) begin
        it.command = CMD_LOAD;
        // a quarter of the loads sit exactly on a pixel grid point
        if ($urandom_range(0, 3) == 0) begin
          it.cent.c0    = {it.pix.c0, 4'b0};
          it.cent.c1    = {it.pix.c1, 4'b0};
          it.cent.c2    = {it.pix.c2, 4'b0};
          last_grid_pix = it.pix;
        end
      end else begin
        it.command = CMD_CLASSIFY;
        if (kind < 37) begin
          // exact seed, either color
          if (kind[0]) it.mark = '{c2: MARK_HI, c1: MARK_LO, c0: MARK_LO};
          else it.mark = '{c2: MARK_LO, c1: MARK_LO, c0: MARK_HI};
        end else if (kind < 45) begin
          // seed with one bit flipped in one channel
          if (kind[0]) it.mark = '{c2: MARK_HI, c1: MARK_LO, c0: MARK_LO};
          else it.mark = '{c2: MARK_LO, c1: MARK_LO, c0: MARK_HI};
          ch = $urandom_range(0, 2);
          case (ch)
            0: it.mark.c0[$urandom_range(0, 7)] ^= 1'b1;
            1: it.mark.c1[$urandom_range(0, 7)] ^= 1'b1;
            default: it.mark.c2[$urandom_range(0, 7)] ^= 1'b1;
          endcase
        end
        // some searches land on a known centroid for zero distances
        if ($urandom_range(0, 4) == 0) it.pix = last_grid_pix;
      end

      // idle gaps, except in one long stretch with none
      if ((i < 100 || i >= 220) && $urandom_range(0, 99) < 15)
        idle_cycles($urandom_range(1, 4));
      // hold off once until the block has emptied
      if (i == 250) drain_results();
      send_item(it);
    end

    // let everything outstanding arrive, then a tail longer than a full search
    drain_results();
    repeat (SEARCH_LAT + 10) @(posedge clk);
    sb.mismatch_count += sb.pending_count();
    if (sb.mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
